>>> hdl/blr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg: shared constants and types of the bicubic line resampler
// Sizes of the line buffer and tap file, operation codes, accumulator widths
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int LINE_DEPTH    = 4096;
  localparam int MAX_TAPS      = 64;
  localparam int FRACTION_BITS = 22;

  localparam int LINE_W    = $clog2(LINE_DEPTH);
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int TAPCNT_W  = 7;
  localparam int CHAN_W    = 8;
  localparam int PIXEL_W   = 3 * CHAN_W;
  localparam int WEIGHT_W  = 24;
  localparam int OP_W      = 2;
  localparam int PROD_W    = CHAN_W + 1 + WEIGHT_W;
  localparam int ACC_W     = PROD_W + TAP_W + 1;
  localparam int CHAN_MAX  = 255;

  localparam logic [OP_W-1:0] OP_STORE_PIXEL  = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE_WEIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE      = 2'd2;

  typedef struct packed {
    logic             start;
    logic             issue;
    logic [TAP_W-1:0] tap;
    logic             wr_pixel;
    logic             wr_weight;
    logic             load_out;
  } blr_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } blr_status_t;

endpackage

>>> hdl/blr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_if: stream channels of the bicubic line resampler
// Input channel carries store and compute items, output channel RGB results.
// ----------------------------------------------------------------------------
interface blr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [blr_pkg::OP_W-1:0]             op;
  logic [11:0]                          pixel_index;
  logic [blr_pkg::CHAN_W-1:0]           red;
  logic [blr_pkg::CHAN_W-1:0]           green;
  logic [blr_pkg::CHAN_W-1:0]           blue;
  logic [5:0]                           tap_index;
  logic signed [blr_pkg::WEIGHT_W-1:0]  weight;
  logic [11:0]                          window_start;
  logic [blr_pkg::TAPCNT_W-1:0]         tap_count;

  modport source (output valid, op, pixel_index, red, green, blue, tap_index,
                  weight, window_start, tap_count, input ready);
  modport sink   (input valid, op, pixel_index, red, green, blue, tap_index,
                  weight, window_start, tap_count, output ready);
endinterface

interface blr_out_if;
  logic                       valid;
  logic                       ready;
  logic [blr_pkg::CHAN_W-1:0] out_red;
  logic [blr_pkg::CHAN_W-1:0] out_green;
  logic [blr_pkg::CHAN_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

>>> hdl/bicubic_line_resampler.sv
`timescale 1ns / 1ps
// A store item is written in the cycle it is accepted, one store per cycle while
// the controller is idle. A compute item with N taps (capped at 64) steps the
// single multiply-accumulate loop one tap per cycle, waits for the datapath to
// drain and loads its result once the output register is free; input is not
// ready again until that load. Reset clears the controller and the output
// valid; line and tap memories hold undefined contents until written.
// ----------------------------------------------------------------------------
// bicubic_line_resampler: one axis pass of a separable bicubic resampler
// Line buffer of RGB8 pixels, a tap weight file and a per-channel fixed-point
// multiply-accumulate with rounding and clamping to 0..255.
// ----------------------------------------------------------------------------
module bicubic_line_resampler (
  input  logic  clk_i,
  input  logic  rst_ni,
  blr_in_if.sink    in_i,
  blr_out_if.source out_o
);

  blr_pkg::blr_cmd_t    cmd;
  blr_pkg::blr_status_t status;
  logic                 out_valid;

  blr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_op_i        (in_i.op),
    .in_tap_count_i (in_i.tap_count),
    .in_ready_o     (in_i.ready),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_o.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  blr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .pixel_index_i  (in_i.pixel_index),
    .red_i          (in_i.red),
    .green_i        (in_i.green),
    .blue_i         (in_i.blue),
    .tap_index_i    (in_i.tap_index),
    .weight_i       (in_i.weight),
    .window_start_i (in_i.window_start),
    .out_red_o      (out_o.out_red),
    .out_green_o    (out_o.out_green),
    .out_blue_o     (out_o.out_blue)
  );

  assign out_o.valid = out_valid;

endmodule

>>> hdl/blr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/blr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_datapath: line buffer, tap file and per-channel multiply-accumulate
// Reads one pixel and one weight per tap, multiplies, accumulates, then
// rounds, shifts and clamps the three sums into the output register.
// ----------------------------------------------------------------------------
module blr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  blr_pkg::blr_cmd_t                   cmd_i,
  output blr_pkg::blr_status_t                status_o,
  input  logic [11:0]                         pixel_index_i,
  input  logic [blr_pkg::CHAN_W-1:0]          red_i,
  input  logic [blr_pkg::CHAN_W-1:0]          green_i,
  input  logic [blr_pkg::CHAN_W-1:0]          blue_i,
  input  logic [5:0]                          tap_index_i,
  input  logic signed [blr_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [11:0]                         window_start_i,
  output logic [blr_pkg::CHAN_W-1:0]          out_red_o,
  output logic [blr_pkg::CHAN_W-1:0]          out_green_o,
  output logic [blr_pkg::CHAN_W-1:0]          out_blue_o
);

  localparam int ACC_W  = blr_pkg::ACC_W;
  localparam int PROD_W = blr_pkg::PROD_W;
  localparam int CHAN_W = blr_pkg::CHAN_W;
  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(1) << (blr_pkg::FRACTION_BITS - 1);

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sh;
    sh = acc >> blr_pkg::FRACTION_BITS;
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (sh > ACC_W'(blr_pkg::CHAN_MAX)) begin
      return CHAN_W'(blr_pkg::CHAN_MAX);
    end else begin
      return sh[CHAN_W-1:0];
    end
  endfunction

  logic [blr_pkg::LINE_W-1:0]          window_q;
  logic [blr_pkg::LINE_W-1:0]          rd_addr;
  logic [blr_pkg::PIXEL_W-1:0]         px_rd;
  logic [blr_pkg::WEIGHT_W-1:0]        w_rd;
  logic                                rd_v_q;
  logic                                prod_v_q;
  logic signed [PROD_W-1:0]            prod_r_d, prod_g_d, prod_b_d;
  logic signed [PROD_W-1:0]            prod_r_q, prod_g_q, prod_b_q;
  logic signed [ACC_W-1:0]             acc_r_q, acc_g_q, acc_b_q;
  logic [CHAN_W-1:0]                   out_r_q, out_g_q, out_b_q;

  // Window position wraps modulo the line depth.
  assign rd_addr = window_q + blr_pkg::LINE_W'(cmd_i.tap);

  blr_ram #(
    .WIDTH (blr_pkg::PIXEL_W),
    .DEPTH (blr_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_pixel),
    .waddr_i (pixel_index_i[blr_pkg::LINE_W-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr),
    .rdata_o (px_rd)
  );

  blr_ram #(
    .WIDTH (blr_pkg::WEIGHT_W),
    .DEPTH (blr_pkg::MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_weight),
    .waddr_i (tap_index_i[blr_pkg::TAP_W-1:0]),
    .wdata_i (weight_i),
    .re_i    (cmd_i.issue),
    .raddr_i (cmd_i.tap),
    .rdata_o (w_rd)
  );

  assign prod_r_d = $signed({1'b0, px_rd[3*CHAN_W-1:2*CHAN_W]}) * $signed(w_rd);
  assign prod_g_d = $signed({1'b0, px_rd[2*CHAN_W-1:CHAN_W]}) * $signed(w_rd);
  assign prod_b_d = $signed({1'b0, px_rd[CHAN_W-1:0]}) * $signed(w_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      window_q <= window_start_i[blr_pkg::LINE_W-1:0];
    end
    if (rd_v_q) begin
      prod_r_q <= prod_r_d;
      prod_g_q <= prod_g_d;
      prod_b_q <= prod_b_d;
    end
    if (cmd_i.start) begin
      acc_r_q <= HALF;
      acc_g_q <= HALF;
      acc_b_q <= HALF;
    end else if (prod_v_q) begin
      acc_r_q <= acc_r_q + {{(ACC_W-PROD_W){prod_r_q[PROD_W-1]}}, prod_r_q};
      acc_g_q <= acc_g_q + {{(ACC_W-PROD_W){prod_g_q[PROD_W-1]}}, prod_g_q};
      acc_b_q <= acc_b_q + {{(ACC_W-PROD_W){prod_b_q[PROD_W-1]}}, prod_b_q};
    end
    if (cmd_i.load_out) begin
      out_r_q <= clamp_chan(acc_r_q);
      out_g_q <= clamp_chan(acc_g_q);
      out_b_q <= clamp_chan(acc_b_q);
    end
  end

  assign status_o.pipe_busy = rd_v_q | prod_v_q;
  assign out_red_o   = out_r_q;
  assign out_green_o = out_g_q;
  assign out_blue_o  = out_b_q;

endmodule

>>> hdl/blr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_ctrl: sequencer of the bicubic line resampler
// Decodes input items, steps the tap counter of a compute item, waits for
// the datapath to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module blr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [blr_pkg::OP_W-1:0]      in_op_i,
  input  logic [blr_pkg::TAPCNT_W-1:0]  in_tap_count_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  blr_pkg::blr_status_t          status_i,
  output blr_pkg::blr_cmd_t             cmd_o
);

  localparam int TAP_W    = blr_pkg::TAP_W;
  localparam int TAPCNT_W = blr_pkg::TAPCNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [TAP_W-1:0]    tap_q, tap_d;
  logic [TAPCNT_W-1:0] taps_q, taps_d;
  logic [TAPCNT_W-1:0] taps_sat;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                last_tap;

  assign taps_sat = (in_tap_count_i > TAPCNT_W'(blr_pkg::MAX_TAPS)) ?
                    TAPCNT_W'(blr_pkg::MAX_TAPS) : in_tap_count_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign last_tap   = (TAPCNT_W'(tap_q) + TAPCNT_W'(1)) == taps_q;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    taps_d  = taps_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            blr_pkg::OP_STORE_PIXEL:  cmd_o.wr_pixel  = 1'b1;
            blr_pkg::OP_STORE_WEIGHT: cmd_o.wr_weight = 1'b1;
            blr_pkg::OP_COMPUTE: begin
              cmd_o.start = 1'b1;
              tap_d       = '0;
              taps_d      = taps_sat;
              state_d     = (taps_sat == '0) ? S_FINISH : S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.tap   = tap_q;
        tap_d       = tap_q + TAP_W'(1);
        if (last_tap) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold the sums until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      taps_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      taps_q      <= taps_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !status_i.pipe_busy)
    else $error("datapath busy while controller idle");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load did not raise output valid");

  a_issue_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> !in_ready_o)
    else $error("input ready while taps are issued");

  a_compute_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op_i == blr_pkg::OP_COMPUTE && taps_sat != '0) |=> (state_q == S_RUN))
    else $error("compute with taps did not start the tap loop");

endmodule

>>> tb/tb_bicubic_line_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bicubic_line_resampler: self-checking bench of the bicubic line resampler
// Drives pixel stores, tap weight stores and compute transactions with random
// idling on both channels, and a long output stall. An in-bench fixed-point
// model predicts every RGB result, and the bench compares each one.
// ----------------------------------------------------------------------------
module tb_bicubic_line_resampler;
  import blr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 1850;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 80;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [11:0]         pixel_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [5:0]          tap_index;
    logic [WEIGHT_W-1:0] weight;
    logic [11:0]         window_start;
    logic [TAPCNT_W-1:0] tap_count;
  } blr_item_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  blr_in_if  in_if ();
  blr_out_if out_if ();

  bicubic_line_resampler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copies of the line buffer and tap file
  logic [PIXEL_W-1:0]         line_mem [LINE_DEPTH];
  logic signed [WEIGHT_W-1:0] tap_mem  [MAX_TAPS];
  rgb_t                       expected_rgb_q [$];

  // Stimulus bookkeeping: what has been written so far, in issue order
  blr_item_t pending_q [$];
  bit        px_written  [LINE_DEPTH];
  bit        tap_written [MAX_TAPS];

  int n_pushed    = 0;
  int n_issued    = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_computes  = 0;
  int n_saturated = 0;
  int n_wrapped   = 0;

  int src_idle_pct  = 17;
  int sink_idle_pct = 70;
  int hold_req      = 0;
  int hold_seen;
  int hold_left;
  int stall_cycles  = 0;

  function automatic logic [CHAN_W-1:0] saturate_chan(longint acc);
    if (acc < 0) return '0;
    acc = acc >>> FRACTION_BITS;
    if (acc > CHAN_MAX) return CHAN_W'(CHAN_MAX);
    return acc[CHAN_W-1:0];
  endfunction

  function automatic rgb_t resample_rgb(logic [11:0] start, logic [TAPCNT_W-1:0] count);
    longint acc_r, acc_g, acc_b, w;
    logic [PIXEL_W-1:0] px;
    int taps;
    rgb_t res;
    taps  = (count > MAX_TAPS) ? MAX_TAPS : int'(count);
    acc_r = longint'(1) << (FRACTION_BITS - 1);
    acc_g = acc_r;
    acc_b = acc_r;
    for (int t = 0; t < taps; t++) begin
      px = line_mem[(int'(start) + t) % LINE_DEPTH];
      w  = tap_mem[t];
      acc_r += longint'(px[23:16]) * w;
      acc_g += longint'(px[15:8]) * w;
      acc_b += longint'(px[7:0]) * w;
    end
    res.red   = saturate_chan(acc_r);
    res.green = saturate_chan(acc_g);
    res.blue  = saturate_chan(acc_b);
    return res;
  endfunction

  function automatic void apply_item(blr_item_t it);
    case (it.op)
      OP_STORE_PIXEL:  line_mem[it.pixel_index] = {it.red, it.green, it.blue};
      OP_STORE_WEIGHT: tap_mem[it.tap_index] = it.weight;
      OP_COMPUTE:      expected_rgb_q.push_back(resample_rgb(it.window_start, it.tap_count));
      default: ;
    endcase
  endfunction

  // Don't-care fields carry random bits too
  function automatic blr_item_t noise_item();
    blr_item_t it;
    it.op           = OP_UNUSED;
    it.pixel_index  = 12'($urandom);
    it.red          = CHAN_W'($urandom);
    it.green        = CHAN_W'($urandom);
    it.blue         = CHAN_W'($urandom);
    it.tap_index    = 6'($urandom);
    it.weight       = WEIGHT_W'($urandom);
    it.window_start = 12'($urandom);
    it.tap_count    = TAPCNT_W'($urandom);
    return it;
  endfunction

  function automatic void queue_item(blr_item_t it);
    pending_q.push_back(it);
    n_pushed++;
    if (it.op != OP_UNUSED) n_issued++;
  endfunction

  function automatic void store_pixel(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    blr_item_t it;
    it             = noise_item();
    it.op          = OP_STORE_PIXEL;
    it.pixel_index = 12'(idx);
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    px_written[idx] = 1'b1;
    queue_item(it);
  endfunction

  function automatic void store_random_pixel(int idx);
    store_pixel(idx, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic void store_weight(int tap, int w);
    blr_item_t it;
    it           = noise_item();
    it.op        = OP_STORE_WEIGHT;
    it.tap_index = 6'(tap);
    it.weight    = WEIGHT_W'(w);
    tap_written[tap] = 1'b1;
    queue_item(it);
  endfunction

  // Mostly weights that sum near unity, sometimes anything in range
  function automatic int pick_weight(int taps);
    int unit;
    if (taps < 1) taps = 1;
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    unit = (1 << FRACTION_BITS) / taps;
    if ($urandom_range(99) < 15) return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
    return int'($urandom_range(0, 2 * unit)) - unit / 4;
  endfunction

  // Fill any tap or pixel the window would read before it is ever written
  function automatic void compute_window(int start, int count);
    blr_item_t it;
    int taps;
    int idx;
    taps = (count > MAX_TAPS) ? MAX_TAPS : count;
    for (int t = 0; t < taps; t++) begin
      idx = (start + t) % LINE_DEPTH;
      if (!tap_written[t]) store_weight(t, pick_weight(8));
      if (!px_written[idx]) store_random_pixel(idx);
    end
    it              = noise_item();
    it.op           = OP_COMPUTE;
    it.window_start = 12'(start);
    it.tap_count    = TAPCNT_W'(count);
    n_computes++;
    if (count > MAX_TAPS) n_saturated++;
    if (start + taps > LINE_DEPTH) n_wrapped++;
    queue_item(it);
  endfunction

  // One output pixel as the host issues it: weights, window, then computes
  function automatic void fill_window(int count);
    int start;
    int taps;
    start = $urandom_range(0, LINE_DEPTH - 1);
    taps  = (count > MAX_TAPS) ? MAX_TAPS : count;
    for (int t = 0; t < taps; t++) store_weight(t, pick_weight(taps));
    for (int t = 0; t < taps; t++) store_random_pixel((start + t) % LINE_DEPTH);
    repeat ($urandom_range(1, 3))
      compute_window((start + $urandom_range(0, 2)) % LINE_DEPTH, count);
  endfunction

  function automatic void random_burst();
    int sel;
    int pick;
    blr_item_t it;
    sel = $urandom_range(99);
    if (sel < 70) begin
      pick = $urandom_range(99);
      if (pick < 3)       fill_window(0);
      else if (pick < 8)  fill_window($urandom_range(65, 127));
      else if (pick < 15) fill_window($urandom_range(10, 64));
      else                fill_window($urandom_range(4, 9));
    end else if (sel < 80) begin
      store_random_pixel($urandom_range(0, LINE_DEPTH - 1));
    end else if (sel < 88) begin
      store_weight($urandom_range(0, MAX_TAPS - 1), pick_weight(8));
    end else if (sel < 93) begin
      it = noise_item();
      queue_item(it);
    end else begin
      compute_window($urandom_range(0, LINE_DEPTH - 1), $urandom_range(0, 12));
    end
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || n_accepted != n_pushed || expected_rgb_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Input side: offer queued transactions, predict each accepted one
  always @(posedge clk_i or negedge rst_ni) begin : feeder
    blr_item_t nxt;
    blr_item_t seen;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        seen.op           = in_if.op;
        seen.pixel_index  = in_if.pixel_index;
        seen.red          = in_if.red;
        seen.green        = in_if.green;
        seen.blue         = in_if.blue;
        seen.tap_index    = in_if.tap_index;
        seen.weight       = in_if.weight;
        seen.window_start = in_if.window_start;
        seen.tap_count    = in_if.tap_count;
        apply_item(seen);
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_q.pop_front();
          in_if.op           <= nxt.op;
          in_if.pixel_index  <= nxt.pixel_index;
          in_if.red          <= nxt.red;
          in_if.green        <= nxt.green;
          in_if.blue         <= nxt.blue;
          in_if.tap_index    <= nxt.tap_index;
          in_if.weight       <= nxt.weight;
          in_if.window_start <= nxt.window_start;
          in_if.tap_count    <= nxt.tap_count;
          in_if.valid        <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each result, apply random and long back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    rgb_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_rgb_q.size() == 0) begin
          if (n_errors < REPORT_MAX)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                     out_if.out_red, out_if.out_green, out_if.out_blue);
          n_errors++;
        end else begin
          want = expected_rgb_q.pop_front();
          n_checked++;
          if (out_if.out_red !== want.red || out_if.out_green !== want.green ||
              out_if.out_blue !== want.blue) begin
            if (n_errors < REPORT_MAX)
              $display("%0t: mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       out_if.out_red, out_if.out_green, out_if.out_blue);
            n_errors++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen    <= hold_req;
        hold_left    <= LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_bicubic_line_resampler failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_UNUSED;
    in_if.pixel_index  = '0;
    in_if.red          = '0;
    in_if.green        = '0;
    in_if.blue         = '0;
    in_if.tap_index    = '0;
    in_if.weight       = '0;
    in_if.window_start = '0;
    in_if.tap_count    = '0;
    out_if.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: weight extremes, clamping both ways, zero taps, wrapped window
    store_weight(0, 8388607);
    store_weight(1, -8388608);
    store_weight(2, 1 << FRACTION_BITS);
    store_weight(MAX_TAPS - 1, -1);
    store_pixel(LINE_DEPTH - 1, 8'd255, 8'd0, 8'd128);
    store_pixel(0, 8'd255, 8'd255, 8'd255);
    store_pixel(1, 8'd1, 8'd2, 8'd3);
    store_pixel(2, 8'd255, 8'd255, 8'd255);
    compute_window(0, 0);
    compute_window(0, 1);
    compute_window(1, 2);
    compute_window(LINE_DEPTH - 1, 3);
    compute_window(2, 1);
    queue_item(noise_item());
    compute_window(1, 1);
    // Full window across the end of the line with a saturated tap count
    compute_window(LINE_DEPTH - 6, 127);
    compute_window(LINE_DEPTH - 6, MAX_TAPS);

    while (n_issued < ITEM_TARGET / 3) random_burst();
    wait_drained();

    src_idle_pct  = 70;
    sink_idle_pct = 17;
    while (n_issued < 2 * ITEM_TARGET / 3) random_burst();
    wait_drained();

    // Hold the output while computes keep arriving so the input backs up
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (int i = 0; i < 6; i++) compute_window($urandom_range(0, LINE_DEPTH - 1), 8);
    hold_req = hold_req + 1;
    while (n_issued < ITEM_TARGET) random_burst();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_rgb_q.size() != 0) n_errors++;
    $display("Accepted %0d transactions and checked %0d RGB results.", n_accepted, n_checked);
    $display("%0d computes: %0d with tap count past %0d, %0d windows wrapping the line.",
             n_computes, n_saturated, MAX_TAPS, n_wrapped);
    if (n_errors == 0) begin
      $display("tb_bicubic_line_resampler passed");
    end else begin
      $display("tb_bicubic_line_resampler failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/blr_pkg.sv
hdl/blr_if.sv
hdl/blr_ram.sv
hdl/blr_datapath.sv
hdl/blr_ctrl.sv
hdl/bicubic_line_resampler.sv
tb/tb_bicubic_line_resampler.sv
